// ===== rtl/core/spectral_subtraction_gain_macros.svh =====
// ----------------------------------------------------------------------------
// spectral subtraction gain assertion macros
// shared concurrent assertion forms used by the top-level rtl file
// ----------------------------------------------------------------------------
`ifndef SPECTRAL_SUBTRACTION_GAIN_MACROS_SVH
`define SPECTRAL_SUBTRACTION_GAIN_MACROS_SVH

// same-cycle implication, disabled in reset
`define SSG_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define SSG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/ssg_pkg.sv =====
// ----------------------------------------------------------------------------
// ssg_pkg
// shared widths, register codes, types and helpers of the gain pipeline
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ssg_pkg;

    // sample and derived widths
    localparam int SAMPLE_BITS = 24;
    localparam int PW          = 2 * SAMPLE_BITS;      // power width
    localparam int BW          = PW + 12;              // mixed power in q12
    localparam int AW          = PW + 16;              // reference power times gain
    localparam int QW          = 48;                   // quotient q0.48
    localparam int RW          = 24;                   // root q0.24
    localparam int FW          = RW + 1;               // gain factor width
    localparam int GW          = 16;                   // overdrive width
    localparam int IW          = 24;                   // inverse frame length width
    localparam int PRW         = SAMPLE_BITS + FW;     // magnitude times factor
    localparam int TW          = PRW + IW;             // full scaled product
    localparam int CFG_DW      = 24;

    // register indexes
    localparam logic CFG_IDX_OVERDRIVE = 1'b0;
    localparam logic CFG_IDX_INV_FRAME = 1'b1;

    // register reset values
    localparam logic [GW-1:0] OVERDRIVE_RESET = GW'(4915);
    localparam logic [IW-1:0] INV_FRAME_RESET = IW'(3277);

    // per-bin data that rides along the pipeline
    typedef struct packed {
        logic                   muted;
        logic                   neg_r;
        logic                   neg_i;
        logic [SAMPLE_BITS-1:0] mag_r;
        logic [SAMPLE_BITS-1:0] mag_i;
    } t_side;

    // magnitude of a two's complement sample
    function automatic logic [SAMPLE_BITS-1:0] mag_of(input logic [SAMPLE_BITS-1:0] v);
        logic [SAMPLE_BITS-1:0] m;
        m = v[SAMPLE_BITS-1] ? (~v + SAMPLE_BITS'(1)) : v;
        return m;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/ssg_power.sv =====
// ----------------------------------------------------------------------------
// ssg_power
// magnitudes, bin powers, scaled reference power and mute decision
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssg_power (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_valid,
    input  wire logic [ssg_pkg::SAMPLE_BITS-1:0] i_mix_real,
    input  wire logic [ssg_pkg::SAMPLE_BITS-1:0] i_mix_imag,
    input  wire logic [ssg_pkg::SAMPLE_BITS-1:0] i_ref_real,
    input  wire logic [ssg_pkg::SAMPLE_BITS-1:0] i_ref_imag,
    input  wire logic [ssg_pkg::GW-1:0]          i_gain,
    output logic                                 o_valid,
    output logic [ssg_pkg::BW-1:0]               o_rem,
    output logic [ssg_pkg::BW-1:0]               o_den,
    output ssg_pkg::t_side                       o_side
);

    localparam int SB = ssg_pkg::SAMPLE_BITS;
    localparam int PW = ssg_pkg::PW;
    localparam int AW = ssg_pkg::AW;

    logic                   r_v1, r_v2, r_v3, r_v4;
    ssg_pkg::t_side         r_s1, r_s2, r_s3, r_s4;
    logic [SB-1:0]          r_rr1, r_ri1;
    logic [ssg_pkg::PW-1:0] r_pm2, r_pr2;
    logic [ssg_pkg::BW-1:0] r_b3, r_b4, r_rem4;
    logic [ssg_pkg::AW-1:0] r_a3;
    logic                   muted;
    ssg_pkg::t_side         side3;

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    // mute when mixed power does not exceed scaled reference, or is zero
    assign muted = (r_b3 <= r_a3) || (r_b3 == '0);

    // side data with the mute decision folded in
    always_comb begin
        side3       = r_s3;
        side3.muted = muted;
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            // stage 1: sign and magnitude
            r_s1.muted <= 1'b0;
            r_s1.neg_r <= i_mix_real[SB-1];
            r_s1.neg_i <= i_mix_imag[SB-1];
            r_s1.mag_r <= ssg_pkg::mag_of(i_mix_real);
            r_s1.mag_i <= ssg_pkg::mag_of(i_mix_imag);
            r_rr1      <= ssg_pkg::mag_of(i_ref_real);
            r_ri1      <= ssg_pkg::mag_of(i_ref_imag);
            // stage 2: powers
            r_s2  <= r_s1;
            r_pm2 <= PW'(r_s1.mag_r) * PW'(r_s1.mag_r) + PW'(r_s1.mag_i) * PW'(r_s1.mag_i);
            r_pr2 <= PW'(r_rr1) * PW'(r_rr1) + PW'(r_ri1) * PW'(r_ri1);
            // stage 3: scale both sides
            r_s3 <= r_s2;
            r_b3 <= {r_pm2, 12'd0};
            r_a3 <= AW'(r_pr2) * AW'(i_gain);
            // stage 4: compare
            r_s4   <= side3;
            r_b4   <= r_b3;
            r_rem4 <= muted ? '0 : r_a3[ssg_pkg::BW-1:0];
        end
    end

    assign o_valid = r_v4;
    assign o_rem   = r_rem4;
    assign o_den   = r_b4;
    assign o_side  = r_s4;

endmodule

`default_nettype wire

// ===== rtl/core/ssg_div.sv =====
// ----------------------------------------------------------------------------
// ssg_div
// pipelined restoring divider, one quotient bit per stage
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssg_div (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic [ssg_pkg::BW-1:0] i_rem,
    input  wire logic [ssg_pkg::BW-1:0] i_den,
    input  wire ssg_pkg::t_side         i_side,
    output logic                        o_valid,
    output logic [ssg_pkg::QW-1:0]      o_quot,
    output ssg_pkg::t_side              o_side
);

    localparam int BW = ssg_pkg::BW;
    localparam int QW = ssg_pkg::QW;

    logic           r_v    [QW];
    logic [BW-1:0]  r_rem  [QW];
    logic [BW-1:0]  r_den  [QW];
    logic [QW-1:0]  r_q    [QW];
    ssg_pkg::t_side r_side [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic           v_in;
        logic [BW-1:0]  rem_in, den_in;
        logic [QW-1:0]  q_in;
        ssg_pkg::t_side side_in;
        logic [BW:0]    sh;
        logic           ge;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign rem_in  = i_rem;
            assign den_in  = i_den;
            assign q_in    = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign rem_in  = r_rem[k-1];
            assign den_in  = r_den[k-1];
            assign q_in    = r_q[k-1];
            assign side_in = r_side[k-1];
        end

        // shift and trial subtract
        assign sh = {rem_in, 1'b0};
        assign ge = sh >= {1'b0, den_in};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? BW'(sh - {1'b0, den_in}) : BW'(sh);
                r_den[k]  <= den_in;
                r_q[k]    <= {q_in[QW-2:0], ge};
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid = r_v[QW-1];
    assign o_quot  = r_q[QW-1];
    assign o_side  = r_side[QW-1];

endmodule

`default_nettype wire

// ===== rtl/core/ssg_sqrt.sv =====
// ----------------------------------------------------------------------------
// ssg_sqrt
// pipelined integer square root, one root bit per stage, gives 1 - root
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssg_sqrt (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_en,
    input  wire logic                   i_valid,
    input  wire logic [ssg_pkg::QW-1:0] i_quot,
    input  wire ssg_pkg::t_side         i_side,
    output logic                        o_valid,
    output logic [ssg_pkg::FW-1:0]      o_factor,
    output ssg_pkg::t_side              o_side
);

    localparam int QW = ssg_pkg::QW;
    localparam int RW = ssg_pkg::RW;
    localparam int FW = ssg_pkg::FW;

    logic           r_v    [RW];
    logic [QW-1:0]  r_q    [RW];
    logic [QW-1:0]  r_res  [RW];
    ssg_pkg::t_side r_side [RW];

    for (genvar k = 0; k < RW; k++) begin : g_stage
        localparam logic [QW-1:0] BIT = QW'(1) << (QW - 2 - 2 * k);
        logic           v_in;
        logic [QW-1:0]  q_in, res_in, trial;
        ssg_pkg::t_side side_in;
        logic           ge;

        if (k == 0) begin : g_first
            assign v_in    = i_valid;
            assign q_in    = i_quot;
            assign res_in  = '0;
            assign side_in = i_side;
        end else begin : g_next
            assign v_in    = r_v[k-1];
            assign q_in    = r_q[k-1];
            assign res_in  = r_res[k-1];
            assign side_in = r_side[k-1];
        end

        // trial subtract of the current root bit
        assign trial = res_in + BIT;
        assign ge    = q_in >= trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[k] <= 1'b0;
            end else if (i_en) begin
                r_v[k] <= v_in;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_q[k]    <= ge ? (q_in - trial) : q_in;
                r_res[k]  <= ge ? ((res_in >> 1) + BIT) : (res_in >> 1);
                r_side[k] <= side_in;
            end
        end
    end

    assign o_valid  = r_v[RW-1];
    assign o_factor = (FW'(1) << RW) - {1'b0, r_res[RW-1][RW-1:0]};
    assign o_side   = r_side[RW-1];

endmodule

`default_nettype wire

// ===== rtl/core/ssg_scale.sv =====
// ----------------------------------------------------------------------------
// ssg_scale
// applies gain factor and inverse frame length, rounds and saturates, zeroes muted bins
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ssg_scale (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_en,
    input  wire logic                            i_valid,
    input  wire logic [ssg_pkg::FW-1:0]          i_factor,
    input  wire ssg_pkg::t_side                  i_side,
    input  wire logic [ssg_pkg::IW-1:0]          i_inv,
    output logic                                 o_valid,
    output logic [ssg_pkg::SAMPLE_BITS-1:0]      o_res_real,
    output logic [ssg_pkg::SAMPLE_BITS-1:0]      o_res_imag,
    output logic                                 o_bin_muted
);

    localparam int SB  = ssg_pkg::SAMPLE_BITS;
    localparam int PRW = ssg_pkg::PRW;
    localparam int TW  = ssg_pkg::TW;
    localparam int YW  = TW + 1 - 48;
    localparam logic [YW-1:0] POS_MAX = YW'((64'd1 << (SB - 1)) - 64'd1);
    localparam logic [YW-1:0] NEG_MAX = YW'(64'd1 << (SB - 1));

    logic           r_v1, r_v2, r_v3;
    ssg_pkg::t_side r_s1, r_s2;
    logic [PRW-1:0] r_pr1, r_pi1;
    logic [TW-1:0]  r_tr2, r_ti2;
    logic [SB-1:0]  r_yr3, r_yi3;
    logic           r_m3;
    logic [SB-1:0]  yr, yi;

    // round half away from zero, then clip to sample range
    function automatic logic [SB-1:0] round_sat(input logic [TW-1:0] t, input logic neg);
        logic [TW:0]   tr;
        logic [YW-1:0] y;
        logic [SB-1:0] out;
        tr = {1'b0, t} + ((TW+1)'(1) << 47);
        y  = tr[TW:48];
        if (neg) begin
            if (y > NEG_MAX) y = NEG_MAX;
            out = SB'(~y + YW'(1));
        end else begin
            if (y > POS_MAX) y = POS_MAX;
            out = SB'(y);
        end
        return out;
    endfunction

    assign yr = round_sat(r_tr2, r_s2.neg_r);
    assign yi = round_sat(r_ti2, r_s2.neg_i);

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // payload stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1  <= i_side;
            r_pr1 <= PRW'(i_side.mag_r) * PRW'(i_factor);
            r_pi1 <= PRW'(i_side.mag_i) * PRW'(i_factor);
            r_s2  <= r_s1;
            r_tr2 <= TW'(r_pr1) * TW'(i_inv);
            r_ti2 <= TW'(r_pi1) * TW'(i_inv);
            r_m3  <= r_s2.muted;
            r_yr3 <= r_s2.muted ? '0 : yr;
            r_yi3 <= r_s2.muted ? '0 : yi;
        end
    end

    assign o_valid     = r_v3;
    assign o_res_real  = r_yr3;
    assign o_res_imag  = r_yi3;
    assign o_bin_muted = r_m3;

endmodule

`default_nettype wire

// ===== rtl/core/spectral_subtraction_gain.sv =====
// ----------------------------------------------------------------------------
// spectral_subtraction_gain
// per-bin spectral subtraction gain stage with configuration registers
// ----------------------------------------------------------------------------
// Takes one mixed and one reference complex bin per clock and returns one
// gated bin per clock while the output is not stalled, passing through the
// powers and mute decision, the pipelined divider (one quotient bit per
// stage), the pipelined square root and the scaling, rounding and output
// register stages. A stall on the output freezes the whole pipeline; no word
// is dropped or repeated. Registers are written through a plain write port;
// write them only while no word is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "spectral_subtraction_gain_macros.svh"

module spectral_subtraction_gain (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_valid,
    output logic                                     o_stall,
    input  wire logic [ssg_pkg::SAMPLE_BITS-1:0]     i_mix_real,
    input  wire logic [ssg_pkg::SAMPLE_BITS-1:0]     i_mix_imag,
    input  wire logic [ssg_pkg::SAMPLE_BITS-1:0]     i_ref_real,
    input  wire logic [ssg_pkg::SAMPLE_BITS-1:0]     i_ref_imag,
    output logic                                     o_valid,
    input  wire logic                                i_stall,
    output logic [ssg_pkg::SAMPLE_BITS-1:0]          o_res_real,
    output logic [ssg_pkg::SAMPLE_BITS-1:0]          o_res_imag,
    output logic                                     o_bin_muted,
    input  wire logic                                i_cfg_we,
    input  wire logic                                i_cfg_index,
    input  wire logic [ssg_pkg::CFG_DW-1:0]          i_cfg_data
);

    logic [ssg_pkg::GW-1:0] r_overdrive_gain;
    logic [ssg_pkg::IW-1:0] r_inv_frame_length;
    logic                   en;

    logic                   pw_valid, dv_valid, sq_valid;
    logic [ssg_pkg::BW-1:0] pw_rem, pw_den;
    ssg_pkg::t_side         pw_side, dv_side, sq_side;
    logic [ssg_pkg::QW-1:0] dv_quot;
    logic [ssg_pkg::FW-1:0] sq_factor;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_overdrive_gain   <= ssg_pkg::OVERDRIVE_RESET;
            r_inv_frame_length <= ssg_pkg::INV_FRAME_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ssg_pkg::CFG_IDX_OVERDRIVE: r_overdrive_gain   <= i_cfg_data[ssg_pkg::GW-1:0];
                ssg_pkg::CFG_IDX_INV_FRAME: r_inv_frame_length <= i_cfg_data[ssg_pkg::IW-1:0];
            endcase
        end
    end

    // pipeline advances unless a finished word is held
    assign o_stall = o_valid && i_stall;
    assign en      = !o_stall;

    ssg_power u_power (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (en),
        .i_valid    (i_valid),
        .i_mix_real (i_mix_real),
        .i_mix_imag (i_mix_imag),
        .i_ref_real (i_ref_real),
        .i_ref_imag (i_ref_imag),
        .i_gain     (r_overdrive_gain),
        .o_valid    (pw_valid),
        .o_rem      (pw_rem),
        .o_den      (pw_den),
        .o_side     (pw_side)
    );

    ssg_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (pw_valid),
        .i_rem   (pw_rem),
        .i_den   (pw_den),
        .i_side  (pw_side),
        .o_valid (dv_valid),
        .o_quot  (dv_quot),
        .o_side  (dv_side)
    );

    ssg_sqrt u_sqrt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (dv_valid),
        .i_quot   (dv_quot),
        .i_side   (dv_side),
        .o_valid  (sq_valid),
        .o_factor (sq_factor),
        .o_side   (sq_side)
    );

    ssg_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (sq_valid),
        .i_factor    (sq_factor),
        .i_side      (sq_side),
        .i_inv       (r_inv_frame_length),
        .o_valid     (o_valid),
        .o_res_real  (o_res_real),
        .o_res_imag  (o_res_imag),
        .o_bin_muted (o_bin_muted)
    );

    // checks
    `SSG_ASSERT_SAME(a_muted_zero, i_clk, i_rst_n, o_valid && o_bin_muted,
        o_res_real == '0 && o_res_imag == '0, "muted word carries nonzero data")
    `SSG_ASSERT_NEXT(a_hold_on_stall, i_clk, i_rst_n, o_stall,
        o_valid && $stable(o_res_real) && $stable(o_bin_muted), "held word changed")
    `SSG_ASSERT_NEXT(a_factor_range, i_clk, i_rst_n, sq_valid && !sq_side.muted && en,
        $past(sq_factor) != '0, "gain factor reached zero")

endmodule

`default_nettype wire

// ===== tb/sv/spectral_subtraction_gain_checker.sv =====
// ----------------------------------------------------------------------------
// spectral_subtraction_gain_checker
// watches the bin channels and register writes, predicts every gated bin and
// compares it field by field with what the block returns
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spectral_subtraction_gain_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic                            i_o_stall,
    input  logic [ssg_pkg::SAMPLE_BITS-1:0] i_mix_real,
    input  logic [ssg_pkg::SAMPLE_BITS-1:0] i_mix_imag,
    input  logic [ssg_pkg::SAMPLE_BITS-1:0] i_ref_real,
    input  logic [ssg_pkg::SAMPLE_BITS-1:0] i_ref_imag,
    input  logic                            i_o_valid,
    input  logic                            i_stall,
    input  logic [ssg_pkg::SAMPLE_BITS-1:0] i_res_real,
    input  logic [ssg_pkg::SAMPLE_BITS-1:0] i_res_imag,
    input  logic                            i_bin_muted,
    input  logic                            i_cfg_we,
    input  logic                            i_cfg_index,
    input  logic [ssg_pkg::CFG_DW-1:0]      i_cfg_data,
    output int                              o_errors,
    output int                              o_pending,
    output int                              o_muted_seen,
    output int                              o_passed_seen
);
    import ssg_pkg::*;

    typedef struct packed {
        logic [SAMPLE_BITS-1:0] re;
        logic [SAMPLE_BITS-1:0] im;
        logic                   muted;
    } gated_bin_t;

    logic [GW-1:0] overdrive_q;
    logic [IW-1:0] inv_frame_q;
    gated_bin_t    expected_bins[$];

    initial begin
        o_errors      = 0;
        o_pending     = 0;
        o_muted_seen  = 0;
        o_passed_seen = 0;
    end

    function automatic logic [SAMPLE_BITS-1:0] abs_sample(input logic [SAMPLE_BITS-1:0] v);
        return v[SAMPLE_BITS-1] ? (~v + 1'b1) : v;
    endfunction

    // scale one part by the gain factor and frame length, round half away, saturate
    function automatic logic [SAMPLE_BITS-1:0] scale_part(input logic [SAMPLE_BITS-1:0] x,
                                                          input logic [127:0] f);
        logic [127:0] t;
        logic [127:0] y;
        t = 128'(abs_sample(x)) * f * 128'(inv_frame_q) + (128'd1 << 47);
        y = t >> 48;
        if (x[SAMPLE_BITS-1]) begin
            if (y > (128'd1 << (SAMPLE_BITS - 1))) y = 128'd1 << (SAMPLE_BITS - 1);
            return SAMPLE_BITS'(~y + 1'b1);
        end
        if (y > (128'd1 << (SAMPLE_BITS - 1)) - 1) y = (128'd1 << (SAMPLE_BITS - 1)) - 1;
        return SAMPLE_BITS'(y);
    endfunction

    function automatic gated_bin_t gate_bin(input logic [SAMPLE_BITS-1:0] mr, mi, rr, ri);
        logic [127:0] mix_pwr;
        logic [127:0] ref_pwr;
        logic [127:0] quot;
        logic [127:0] root;
        logic [127:0] cand;
        gated_bin_t   g;
        mix_pwr = (128'(abs_sample(mr)) * 128'(abs_sample(mr))
                 + 128'(abs_sample(mi)) * 128'(abs_sample(mi))) << 12;
        ref_pwr = (128'(abs_sample(rr)) * 128'(abs_sample(rr))
                 + 128'(abs_sample(ri)) * 128'(abs_sample(ri))) * 128'(overdrive_q);
        g = '0;
        if (mix_pwr <= ref_pwr) begin
            g.muted = 1'b1;
            return g;
        end
        // q0.48 ratio, then its q0.24 root
        quot = (ref_pwr << 48) / mix_pwr;
        root = 0;
        for (int b = 23; b >= 0; b--) begin
            cand = root | (128'd1 << b);
            if (cand * cand <= quot) root = cand;
        end
        g.re = scale_part(mr, (128'd1 << 24) - root);
        g.im = scale_part(mi, (128'd1 << 24) - root);
        return g;
    endfunction

    task automatic report_mismatch(input string what, input logic [SAMPLE_BITS-1:0] got,
                                   input logic [SAMPLE_BITS-1:0] want);
        $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
        o_errors++;
    endtask

    // register shadow, new bins in, gated bins out
    always @(posedge i_clk) begin
        gated_bin_t want;
        if (!i_rst_n) begin
            overdrive_q <= OVERDRIVE_RESET;
            inv_frame_q <= INV_FRAME_RESET;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_IDX_OVERDRIVE) overdrive_q <= i_cfg_data[GW-1:0];
                else inv_frame_q <= i_cfg_data[IW-1:0];
            end
            if (i_valid && !i_o_stall)
                expected_bins.push_back(gate_bin(i_mix_real, i_mix_imag,
                                                 i_ref_real, i_ref_imag));
            if (i_o_valid && !i_stall) begin
                if (expected_bins.size() == 0) begin
                    report_mismatch("word with no bin outstanding", i_res_real, '0);
                end else begin
                    want = expected_bins.pop_front();
                    if (i_res_real !== want.re) report_mismatch("res_real", i_res_real, want.re);
                    if (i_res_imag !== want.im) report_mismatch("res_imag", i_res_imag, want.im);
                    if (i_bin_muted !== want.muted)
                        report_mismatch("bin_muted", i_bin_muted, want.muted);
                    if (want.muted) o_muted_seen++;
                    else o_passed_seen++;
                end
            end
            o_pending = expected_bins.size();
        end
    end

endmodule

// ===== tb/sv/spectral_subtraction_gain_tb.sv =====
// ----------------------------------------------------------------------------
// spectral_subtraction_gain_tb
// drives mixed and reference bins through the gain stage over several register
// settings with random gaps and output stalls; the checker judges each word
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spectral_subtraction_gain_tb;
    import ssg_pkg::*;

    localparam int DRAIN_CYCLES = 100;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_valid;
    logic                   o_stall;
    logic [SAMPLE_BITS-1:0] i_mix_real;
    logic [SAMPLE_BITS-1:0] i_mix_imag;
    logic [SAMPLE_BITS-1:0] i_ref_real;
    logic [SAMPLE_BITS-1:0] i_ref_imag;
    logic                   o_valid;
    logic                   i_stall;
    logic [SAMPLE_BITS-1:0] o_res_real;
    logic [SAMPLE_BITS-1:0] o_res_imag;
    logic                   o_bin_muted;
    logic                   i_cfg_we;
    logic                   i_cfg_index;
    logic [CFG_DW-1:0]      i_cfg_data;

    int  errors;
    int  pending;
    int  muted_seen;
    int  passed_seen;
    int  bins_sent;
    int  settings_run;
    bit  calm_in;
    bit  calm_out;

    spectral_subtraction_gain dut (.*);

    spectral_subtraction_gain_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_o_stall    (o_stall),
        .i_mix_real   (i_mix_real),
        .i_mix_imag   (i_mix_imag),
        .i_ref_real   (i_ref_real),
        .i_ref_imag   (i_ref_imag),
        .i_o_valid    (o_valid),
        .i_stall      (i_stall),
        .i_res_real   (o_res_real),
        .i_res_imag   (o_res_imag),
        .i_bin_muted  (o_bin_muted),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_errors     (errors),
        .o_pending    (pending),
        .o_muted_seen (muted_seen),
        .o_passed_seen(passed_seen)
    );

    // 8 ns clock
    initial i_clk = 1'b0;
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // hard stop
    initial begin
        #4ms;
        $display("spectral_subtraction_gain_tb: done, errors");
        $finish;
    end

    // output stall pattern: a drawn hold-off before each word, calm stretches too
    initial begin
        int n;
        i_stall = 1'b1;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if ($urandom_range(0, 99) < 3) calm_out = !calm_out;
            n = calm_out ? 0 : $urandom_range(0, 17);
            if (n > 0) begin
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    task automatic send_bin(input logic [SAMPLE_BITS-1:0] mr, mi, rr, ri);
        int gap;
        if ($urandom_range(0, 99) < 3) calm_in = !calm_in;
        gap = calm_in ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_mix_real <= mr;
        i_mix_imag <= mi;
        i_ref_real <= rr;
        i_ref_imag <= ri;
        do @(posedge i_clk); while (o_stall);
        bins_sent++;
    endtask

    // registers change only with the pipeline empty
    task automatic set_registers(input logic [GW-1:0] gain, input logic [IW-1:0] inv);
        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_IDX_OVERDRIVE;
        i_cfg_data  <= {8'($urandom), gain};   // upper bits must be ignored
        @(posedge i_clk);
        i_cfg_index <= CFG_IDX_INV_FRAME;
        i_cfg_data  <= inv;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // corner bins: extremes, zero power, equal power, lone parts
    task automatic corner_bins();
        logic [SAMPLE_BITS-1:0] pmax;
        logic [SAMPLE_BITS-1:0] nmax;
        pmax = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        nmax = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        send_bin(pmax, pmax, '0, '0);
        send_bin(nmax, nmax, '0, '0);
        send_bin(pmax, nmax, 24'd1, '0);
        send_bin('0, '0, '0, '0);
        send_bin('0, '0, pmax, nmax);
        send_bin(pmax, pmax, pmax, pmax);
        send_bin(nmax, '0, '0, nmax);
        send_bin(24'd1, '1, '0, '0);
        send_bin(pmax, '0, 24'(pmax >> 1), '0);
        send_bin('1, 24'd1, '0, '0);
        send_bin(nmax, pmax, 24'h100000, 24'hF00000);
        send_bin(24'h000123, 24'hFFFEDC, 24'h000010, 24'h000000);
    endtask

    // random bins: mostly a reference a few bits below the mix so both outcomes occur
    task automatic random_bins(input int count);
        logic [SAMPLE_BITS-1:0] mr;
        logic [SAMPLE_BITS-1:0] mi;
        logic [SAMPLE_BITS-1:0] rr;
        logic [SAMPLE_BITS-1:0] ri;
        int                     sh;
        repeat (count) begin
            mr = $urandom;
            mi = $urandom;
            rr = $urandom;
            ri = $urandom;
            case ($urandom_range(0, 4))
                0: ;
                1, 2: begin
                    sh = $urandom_range(0, 4);
                    rr = $signed(mr) >>> sh;
                    ri = $signed(mi) >>> sh;
                    rr ^= 24'($urandom_range(0, 255));
                end
                3: begin
                    sh = $urandom_range(8, 20);
                    mr = $signed(mr) >>> sh;
                    mi = $signed(mi) >>> sh;
                    rr = $signed(rr) >>> (sh + $urandom_range(0, 3));
                    ri = $signed(ri) >>> (sh + $urandom_range(0, 3));
                end
                default: begin
                    rr = $urandom_range(0, 1) ? '0 : 24'($urandom_range(0, 15));
                    ri = '0;
                end
            endcase
            send_bin(mr, mi, rr, ri);
        end
    endtask

    // stimulus
    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_mix_real  = '0;
        i_mix_imag  = '0;
        i_ref_real  = '0;
        i_ref_imag  = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = CFG_IDX_OVERDRIVE;
        i_cfg_data  = '0;
        calm_in     = 1'b0;
        calm_out    = 1'b0;
        bins_sent   = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings
        corner_bins();
        random_bins(230);
        settings_run = 1;

        // extremes and a few ordinary settings
        set_registers('0, '1);
        corner_bins();
        random_bins(200);
        set_registers('1, 24'd1);
        corner_bins();
        random_bins(200);
        set_registers(16'd4096, '0);
        random_bins(150);
        set_registers(16'd1, 24'hFFFFFF);
        corner_bins();
        random_bins(200);
        set_registers(16'($urandom_range(1, 12000)), 24'($urandom_range(1, 24'hFFFFFF)));
        random_bins(230);
        set_registers(16'($urandom), 24'h800000);
        corner_bins();
        random_bins(200);
        settings_run = 7;

        i_valid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("sent %0d bins over %0d register settings", bins_sent, settings_run);
        $display("returned %0d muted and %0d passed bins", muted_seen, passed_seen);
        if (errors == 0) begin
            $display("spectral_subtraction_gain_tb: done, clean");
        end else begin
            $display("spectral_subtraction_gain_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/ssg_pkg.sv
rtl/core/ssg_power.sv
rtl/core/ssg_div.sv
rtl/core/ssg_sqrt.sv
rtl/core/ssg_scale.sv
rtl/core/spectral_subtraction_gain.sv
tb/sv/spectral_subtraction_gain_checker.sv
tb/sv/spectral_subtraction_gain_tb.sv
